@@ design/tpc_pkg.sv @@
package tpc_pkg;

   localparam int GROUP_SIZE = 256;
   localparam int DOT_W = 50;
   localparam int SCR_W = 50;
   localparam int INT_W = 36;

   typedef struct packed {
      logic [23:0]        tri_index;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] c_x;
      logic signed [31:0] c_y;
      logic signed [31:0] c_z;
   } req_type;

   typedef struct packed {
      logic [23:0]        out_index;
      logic [7:0]         list_slot;
      logic signed [31:0] a_sx;
      logic signed [31:0] a_sy;
      logic signed [31:0] b_sx;
      logic signed [31:0] b_sy;
      logic signed [31:0] c_sx;
      logic signed [31:0] c_sy;
      logic [30:0]        a_depth;
      logic [30:0]        b_depth;
      logic [30:0]        c_depth;
   } rsp_type;

   // item as it sits in the front queue, tagged with its group change
   typedef struct packed {
      req_type req;
      logic    grp_new;
   } fq_type;

   typedef struct packed {
      logic [47:0] view_forward;
      logic [47:0] view_right;
      logic [47:0] view_up;
      logic [31:0] screen_scale;
      logic [13:0] screen_width;
      logic [13:0] screen_height;
      logic [31:0] clip_x_limit;
      logic [31:0] clip_y_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      CSR_VIEW_FORWARD  = 4'd0,
      CSR_VIEW_RIGHT    = 4'd1,
      CSR_VIEW_UP       = 4'd2,
      CSR_SCREEN_SCALE  = 4'd3,
      CSR_SCREEN_WIDTH  = 4'd4,
      CSR_SCREEN_HEIGHT = 4'd5,
      CSR_CLIP_X_LIMIT  = 4'd6,
      CSR_CLIP_Y_LIMIT  = 4'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHK,
      ST_DIV,
      ST_SCR,
      ST_BOX
   } back_state_type;

   typedef enum logic [1:0] {
      DSEL_DEPTH = 2'd0,
      DSEL_X     = 2'd1,
      DSEL_Y     = 2'd2
   } dsel_type;

endpackage

@@ design/tpc_front.sv @@
module tpc_front import tpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    item_valid,
   output fq_type  item,
   input  logic    item_take
);

   fq_type      mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;
   logic [15:0] grp_ff;
   logic [15:0] grp;
   logic        push_ok, pop_ok;

   assign grp        = 16'(req_data.tri_index / GROUP_SIZE);
   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = mem_ff[rd_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ff] <= '{req: req_data, grp_new: (grp != grp_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
         grp_ff <= 16'd0;
      end else begin
         if (push_ok) begin
            wr_ff  <= !wr_ff;
            grp_ff <= grp;
         end
         if (pop_ok) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(pop_ok);
      end
   end

endmodule

@@ design/tpc_div.sv @@
module tpc_div import tpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [47:0] den,
   output logic        done,
   output logic [31:0] quo,
   output logic        ovf
);

   logic        busy_ff, done_ff, ovf_ff;
   logic [5:0]  cnt_ff;
   logic [47:0] rem_ff, den_ff;
   logic [31:0] nb_ff, quo_ff;
   logic [48:0] trial;
   logic        fits, ovf_in;

   // quotient of 2^32 or more does not fit
   assign ovf_in = {16'd0, num} >= {den, 32'd0};
   assign trial  = {rem_ff, nb_ff[31]};
   assign fits   = trial >= {1'b0, den_ff};
   assign done   = done_ff;
   assign quo    = quo_ff;
   assign ovf    = ovf_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         ovf_ff <= ovf_in;
         quo_ff <= 32'd0;
         rem_ff <= {16'd0, num[63:32]};
         nb_ff  <= num[31:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? 48'(trial - {1'b0, den_ff}) : trial[47:0];
         quo_ff <= {quo_ff[30:0], fits};
         nb_ff  <= {nb_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !ovf_in;
            done_ff <= ovf_in;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

@@ design/tpc_back.sv @@
module tpc_back import tpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    item_valid,
   input  fq_type  item,
   output logic    item_take,
   output logic    rsp_push,
   output rsp_type rsp,
   input  logic    rsp_full
);

   back_state_type state_ff, state_in;
   fq_type                  item_ff;
   logic [1:0]              vtx_ff;
   logic [3:0]              k_ff;
   dsel_type                dsel_ff;
   logic signed [DOT_W-1:0] df_ff, dr_ff, du_ff;
   logic signed [47:0]      prod_ff;
   logic [1:0]              pb_ff;
   logic [30:0]             depth_ff [3];
   logic signed [SCR_W-1:0] sx_ff [3];
   logic signed [SCR_W-1:0] sy_ff [3];
   logic [31:0]             offx_ff, offy_ff;
   logic [63:0]             msc_ff;
   logic                    cull_ff;
   logic [8:0]              count_ff;

   logic [1:0]              b_idx, c_idx;
   logic signed [31:0]      p_sel;
   logic [47:0]             basis;
   logic signed [15:0]      comp;
   logic signed [47:0]      mul_prod;
   logic                    div_start, div_done, div_ovf;
   logic [31:0]             div_quo;
   logic [63:0]             div_num;
   dsel_type                nsel;
   logic [DOT_W-1:0]        mag;
   logic                    fail;
   logic [63:0]             scr_prod;
   logic signed [SCR_W-1:0] scr_val;
   logic signed [INT_W-1:0] ix [3];
   logic signed [INT_W-1:0] iy [3];
   logic signed [INT_W-1:0] minx, maxx, miny, maxy, w, h;
   logic                    box_ok;
   logic [8:0]              count_eff;

   function automatic logic signed [INT_W-1:0] int_part(logic signed [SCR_W-1:0] s);
      logic [SCR_W-1:0] m;
      m = s[SCR_W-1] ? SCR_W'(-s) : SCR_W'(s);
      m = m >> 16;
      return s[SCR_W-1] ? -INT_W'(m) : INT_W'(m);
   endfunction

   function automatic logic signed [INT_W-1:0] min3(logic signed [INT_W-1:0] a,
         logic signed [INT_W-1:0] b, logic signed [INT_W-1:0] c);
      logic signed [INT_W-1:0] m;
      m = (b < a) ? b : a;
      return (c < m) ? c : m;
   endfunction

   function automatic logic signed [INT_W-1:0] max3(logic signed [INT_W-1:0] a,
         logic signed [INT_W-1:0] b, logic signed [INT_W-1:0] c);
      logic signed [INT_W-1:0] m;
      m = (b > a) ? b : a;
      return (c > m) ? c : m;
   endfunction

   function automatic logic [31:0] sat32(logic signed [SCR_W-1:0] s);
      if (s > SCR_W'(64'sd2147483647)) return 32'h7FFF_FFFF;
      if (s < -SCR_W'(64'sd2147483648)) return 32'h8000_0000;
      return s[31:0];
   endfunction

   tpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (df_ff[47:0]),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // dot product term selection: basis b, component c
   always_comb begin
      case (k_ff)
         4'd0: begin b_idx = 2'd0; c_idx = 2'd0; end
         4'd1: begin b_idx = 2'd0; c_idx = 2'd1; end
         4'd2: begin b_idx = 2'd0; c_idx = 2'd2; end
         4'd3: begin b_idx = 2'd1; c_idx = 2'd0; end
         4'd4: begin b_idx = 2'd1; c_idx = 2'd1; end
         4'd5: begin b_idx = 2'd1; c_idx = 2'd2; end
         4'd6: begin b_idx = 2'd2; c_idx = 2'd0; end
         4'd7: begin b_idx = 2'd2; c_idx = 2'd1; end
         4'd8: begin b_idx = 2'd2; c_idx = 2'd2; end
         default: begin b_idx = 2'd0; c_idx = 2'd0; end
      endcase
      case ({vtx_ff, c_idx})
         4'b0000: p_sel = item_ff.req.a_x;
         4'b0001: p_sel = item_ff.req.a_y;
         4'b0010: p_sel = item_ff.req.a_z;
         4'b0100: p_sel = item_ff.req.b_x;
         4'b0101: p_sel = item_ff.req.b_y;
         4'b0110: p_sel = item_ff.req.b_z;
         4'b1000: p_sel = item_ff.req.c_x;
         4'b1001: p_sel = item_ff.req.c_y;
         4'b1010: p_sel = item_ff.req.c_z;
         default: p_sel = 32'sd0;
      endcase
      case (b_idx)
         2'd0:    basis = cfg.view_forward;
         2'd1:    basis = cfg.view_right;
         default: basis = cfg.view_up;
      endcase
      comp     = $signed(basis[16*c_idx +: 16]);
      mul_prod = 48'(p_sel) * 48'(comp);
   end

   // divider operand for the division about to start, and the clip check on the one just done
   always_comb begin
      nsel = (state_ff == ST_CHK) ? DSEL_DEPTH : dsel_type'(dsel_ff + 2'd1);
      mag  = '0;
      case (nsel)
         DSEL_X: begin
            mag = dr_ff[DOT_W-1] ? DOT_W'(-dr_ff) : DOT_W'(dr_ff);
         end
         DSEL_Y: begin
            mag = du_ff[DOT_W-1] ? DOT_W'(-du_ff) : DOT_W'(du_ff);
         end
         default: mag = '0;
      endcase
      div_num = (nsel == DSEL_DEPTH) ? (64'd1 << 54) : {mag[47:0], 16'd0};
      case (dsel_ff)
         DSEL_X:  fail = div_ovf || (div_quo >= cfg.clip_x_limit);
         DSEL_Y:  fail = div_ovf || (div_quo >= cfg.clip_y_limit);
         default: fail = 1'b0;
      endcase
   end

   // screen mapping about the centre, x mirrored
   always_comb begin
      logic signed [SCR_W-1:0] pe, half;
      logic                    neg;
      scr_prod = 64'(k_ff == 4'd0 ? offx_ff : offy_ff) * 64'(cfg.screen_scale);
      pe       = SCR_W'($signed({2'b00, msc_ff[63:16]}));
      if (k_ff == 4'd1) begin
         neg  = !dr_ff[DOT_W-1];
         half = SCR_W'($signed({1'b0, cfg.screen_width[13:1], 16'd0}));
      end else begin
         neg  = du_ff[DOT_W-1];
         half = SCR_W'($signed({1'b0, cfg.screen_height[13:1], 16'd0}));
      end
      scr_val = (neg ? -pe : pe) + half;
   end

   // bounding box tests
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         ix[v] = int_part(sx_ff[v]);
         iy[v] = int_part(sy_ff[v]);
      end
      minx   = min3(ix[0], ix[1], ix[2]);
      maxx   = max3(ix[0], ix[1], ix[2]);
      miny   = min3(iy[0], iy[1], iy[2]);
      maxy   = max3(iy[0], iy[1], iy[2]);
      w      = INT_W'($signed({1'b0, cfg.screen_width}));
      h      = INT_W'($signed({1'b0, cfg.screen_height}));
      box_ok = !cull_ff && !(maxx - minx > w) && !(maxy - miny > h)
               && !maxx[INT_W-1] && !maxy[INT_W-1] && !(minx > w) && !(miny > h);
      count_eff = item_ff.grp_new ? 9'd0 : count_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (item_valid) state_in = ST_MUL;
         ST_MUL:  if (k_ff == 4'd9) state_in = ST_CHK;
         ST_CHK:  state_in = (df_ff <= 0) ? ST_BOX : ST_DIV;
         ST_DIV: begin
            if (div_done && fail) begin
               state_in = ST_BOX;
            end else if (div_done && dsel_ff == DSEL_Y) begin
               state_in = ST_SCR;
            end
         end
         ST_SCR: begin
            if (k_ff == 4'd2) state_in = (vtx_ff == 2'd2) ? ST_BOX : ST_MUL;
         end
         ST_BOX:  if (!box_ok || !rsp_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_take = 1'b0;
      div_start = 1'b0;
      rsp_push  = 1'b0;
      case (state_ff)
         ST_IDLE: item_take = item_valid;
         ST_CHK:  div_start = (df_ff > 0);
         ST_DIV:  div_start = div_done && !fail && (dsel_ff != DSEL_Y);
         ST_BOX:  rsp_push  = box_ok && !rsp_full;
         default: ;
      endcase
   end

   always_comb begin
      rsp.out_index = item_ff.req.tri_index;
      rsp.list_slot = count_eff[7:0];
      rsp.a_sx      = sat32(sx_ff[0]);
      rsp.a_sy      = sat32(sy_ff[0]);
      rsp.b_sx      = sat32(sx_ff[1]);
      rsp.b_sy      = sat32(sy_ff[1]);
      rsp.c_sx      = sat32(sx_ff[2]);
      rsp.c_sy      = sat32(sy_ff[2]);
      rsp.a_depth   = depth_ff[0];
      rsp.b_depth   = depth_ff[1];
      rsp.c_depth   = depth_ff[2];
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (item_valid) item_ff <= item;
         ST_MUL: begin
            if (k_ff == 4'd0) begin
               df_ff <= '0;
               dr_ff <= '0;
               du_ff <= '0;
            end else begin
               case (pb_ff)
                  2'd0:    df_ff <= df_ff + DOT_W'(prod_ff);
                  2'd1:    dr_ff <= dr_ff + DOT_W'(prod_ff);
                  default: du_ff <= du_ff + DOT_W'(prod_ff);
               endcase
            end
            prod_ff <= mul_prod;
            pb_ff   <= b_idx;
         end
         ST_DIV: begin
            if (div_done) begin
               case (dsel_ff)
                  DSEL_DEPTH: begin
                     depth_ff[vtx_ff] <= (div_ovf || div_quo[31]) ? 31'h7FFF_FFFF
                                                                 : div_quo[30:0];
                  end
                  DSEL_X:  offx_ff <= div_quo;
                  default: offy_ff <= div_quo;
               endcase
            end
         end
         ST_SCR: begin
            msc_ff <= scr_prod;
            if (k_ff == 4'd1) sx_ff[vtx_ff] <= scr_val;
            if (k_ff == 4'd2) sy_ff[vtx_ff] <= scr_val;
         end
         default: ;
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vtx_ff   <= 2'd0;
         k_ff     <= 4'd0;
         dsel_ff  <= DSEL_DEPTH;
         cull_ff  <= 1'b0;
         count_ff <= 9'd0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               vtx_ff  <= 2'd0;
               k_ff    <= 4'd0;
               cull_ff <= 1'b0;
            end
            ST_MUL: k_ff <= k_ff + 4'd1;
            ST_CHK: begin
               dsel_ff <= DSEL_DEPTH;
               if (df_ff <= 0) cull_ff <= 1'b1;
            end
            ST_DIV: begin
               if (div_done) begin
                  if (fail) cull_ff <= 1'b1;
                  dsel_ff <= nsel;
                  k_ff    <= 4'd0;
               end
            end
            ST_SCR: begin
               if (k_ff == 4'd2) begin
                  k_ff   <= 4'd0;
                  vtx_ff <= vtx_ff + 2'd1;
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            ST_BOX: begin
               if (!box_ok) begin
                  count_ff <= count_eff;
               end else if (!rsp_full) begin
                  count_ff <= count_eff + 9'd1;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

@@ design/tpc_rspq.sv @@
module tpc_rspq import tpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type din,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   rsp_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push_ok, pop_ok;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = mem_ff[rd_ff];
   assign push_ok   = push && !full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_ok) wr_ff <= !wr_ff;
         if (pop_ok) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(pop_ok);
      end
   end

endmodule

@@ design/triangle_project_and_cull.sv @@
// Triangle projection and culling.
// Request channel: present a triangle on req_data and raise req_push; it is
// taken at a clock edge where req_full is low. A two-entry front queue holds
// items and tags each with whether its group (tri_index / 256) changed.
// Response channel: while rsp_empty is low, rsp_data holds the oldest surviving
// triangle; raise rsp_pop to take it. Culled triangles produce no item.
// CSR channel: csr_ready is always high; write csr_wdata to register csr_index
// only while the block is idle.
// Engine: it works on one triangle at a time, and stops early on a culled one.
// Per vertex: dot products on one 32x16 multiplier, a check of the forward
// dot, then three divisions (depth, x, y) on the shared one-bit-per-cycle
// divider, then screen mapping; the triangle is loaded before the first
// vertex and its box is tested after the last. While the engine is busy, the
// front queue can still take new requests as long as it has room.
// Stall: when the response queue fills, the engine holds its finished triangle
// and the front queue keeps taking requests until it fills too.
// Reset: queues empty, group and slot count cleared, registers to defaults.
module triangle_project_and_cull import tpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    item_valid, item_take;
   fq_type  item;
   logic    bk_push, q_full;
   rsp_type bk_rsp;

   assign csr_ready = 1'b1;

   // register file: decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VIEW_FORWARD:  cfg_in.view_forward  = csr_wdata;
            CSR_VIEW_RIGHT:    cfg_in.view_right    = csr_wdata;
            CSR_VIEW_UP:       cfg_in.view_up       = csr_wdata;
            CSR_SCREEN_SCALE:  cfg_in.screen_scale  = csr_wdata[31:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[13:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[13:0];
            CSR_CLIP_X_LIMIT:  cfg_in.clip_x_limit  = csr_wdata[31:0];
            CSR_CLIP_Y_LIMIT:  cfg_in.clip_y_limit  = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_forward  <= 48'h4000_0000_0000;
         cfg_ff.view_right    <= 48'h0000_0000_4000;
         cfg_ff.view_up       <= 48'h0000_4000_0000;
         cfg_ff.screen_scale  <= 32'h0001_0000;
         cfg_ff.screen_width  <= 14'd640;
         cfg_ff.screen_height <= 14'd480;
         cfg_ff.clip_x_limit  <= 32'h0001_0000;
         cfg_ff.clip_y_limit  <= 32'h0001_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept and tag
   tpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // project, divide, cull, assign slot
   tpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_push   (bk_push),
      .rsp        (bk_rsp),
      .rsp_full   (q_full)
   );

   // hold results for the receiver
   tpc_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (bk_push),
      .din       (bk_rsp),
      .full      (q_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/tpc_checker.sv @@
module tpc_checker import tpc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // full only rises after an accepted push
   a_full_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("req_full rose without a push");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind triangle_project_and_cull tpc_checker u_tpc_checker (.*);

@@ tb/testbench.sv @@
module testbench;
   import tpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [47:0] csr_wdata;

   triangle_project_and_cull dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the block's registers and group state
   logic [47:0] cf_forward, cf_right, cf_up;
   logic [31:0] cf_scale, cf_clip_x, cf_clip_y;
   logic [13:0] cf_width, cf_height;
   logic [15:0] cur_group;
   logic [8:0]  slot_count;

   req_type triangles_pending[$];
   rsp_type surviving_triangles[$];
   int      send_idle_pct, recv_idle_pct;
   int      mismatch_count, error_count;
   logic [23:0] next_index;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic longint dot3(longint x, longint y, longint z, logic [47:0] b);
      return x * longint'($signed(b[15:0])) + y * longint'($signed(b[31:16]))
           + z * longint'($signed(b[47:32]));
   endfunction

   // Q16.16 offset num/den truncated toward zero; zero when not inside the limit.
   // The shift wraps at 64 bits just as the block's datapath does.
   function automatic bit offset_inside(longint num, longint den, logic [63:0] lim,
                                        output longint res);
      logic [63:0] m, q, d;
      m = num < 0 ? -num : num;
      d = den;
      q = (m << 16) / d;
      res = 0;
      if (q >= lim) return 1'b0;
      res = num < 0 ? -longint'(q) : longint'(q);
      return 1'b1;
   endfunction

   function automatic longint to_screen(longint off, logic [31:0] scale,
                                        logic [13:0] size, bit mirror);
      logic [63:0] m, p, sc;
      bit neg;
      m = off < 0 ? -off : off;
      sc = scale;
      p = (m * sc) >> 16;
      neg = (off < 0) != mirror;
      return (neg ? -longint'(p) : longint'(p)) + (longint'(size >> 1) <<< 16);
   endfunction

   function automatic longint int_part(longint v);
      return v >= 0 ? (v >>> 16) : -((-v) >>> 16);
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Work out the screen setup of one triangle and advance the group state.
   // Returns 1 when the triangle survives culling.
   function automatic bit project_triangle(req_type t, output rsp_type r);
      logic [15:0] grp;
      longint px, py, pz, df, dx, dy, ox, oy, ix, iy;
      longint sx[3], sy[3];
      logic [63:0] q;
      logic [30:0] dep[3];
      longint mnx, mxx, mny, mxy;
      r = '0;
      mnx = 0; mxx = 0; mny = 0; mxy = 0;
      grp = 16'(t.tri_index / GROUP_SIZE);
      if (grp != cur_group) begin
         cur_group = grp;
         slot_count = '0;
      end
      for (int v = 0; v < 3; v++) begin
         case (v)
            0: begin px = t.a_x; py = t.a_y; pz = t.a_z; end
            1: begin px = t.b_x; py = t.b_y; pz = t.b_z; end
            default: begin px = t.c_x; py = t.c_y; pz = t.c_z; end
         endcase
         df = dot3(px, py, pz, cf_forward);
         dx = dot3(px, py, pz, cf_right);
         dy = dot3(px, py, pz, cf_up);
         if (df <= 0) return 1'b0;
         q = (64'd1 << 54) / $unsigned(df);
         dep[v] = q > 64'h7fffffff ? 31'h7fffffff : q[30:0];
         if (!offset_inside(dx, df, 64'(cf_clip_x), ox)) return 1'b0;
         if (!offset_inside(dy, df, 64'(cf_clip_y), oy)) return 1'b0;
         sx[v] = to_screen(ox, cf_scale, cf_width, 1'b1);
         sy[v] = to_screen(oy, cf_scale, cf_height, 1'b0);
         ix = int_part(sx[v]);
         iy = int_part(sy[v]);
         if (v == 0 || ix < mnx) mnx = ix;
         if (v == 0 || ix > mxx) mxx = ix;
         if (v == 0 || iy < mny) mny = iy;
         if (v == 0 || iy > mxy) mxy = iy;
      end
      if (mxx - mnx > longint'(cf_width) || mxy - mny > longint'(cf_height)) return 1'b0;
      if (mxx < 0 || mxy < 0) return 1'b0;
      if (mnx > longint'(cf_width) || mny > longint'(cf_height)) return 1'b0;
      r.out_index = t.tri_index;
      r.list_slot = slot_count[7:0];
      slot_count = slot_count + 9'd1;
      r.a_sx = sat32(sx[0]); r.a_sy = sat32(sy[0]);
      r.b_sx = sat32(sx[1]); r.b_sy = sat32(sy[1]);
      r.c_sx = sat32(sx[2]); r.c_sy = sat32(sy[2]);
      r.a_depth = dep[0]; r.b_depth = dep[1]; r.c_depth = dep[2];
      return 1'b1;
   endfunction

   // Driver: hold an item until it is taken, then advance to the next one.
   always @(posedge clock) begin
      rsp_type r;
      bit      taken;
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            if (project_triangle(req_data, r)) surviving_triangles.push_back(r);
            void'(triangles_pending.pop_front());
         end
         if (!req_push || taken) begin
            if (triangles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= triangles_pending[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each popped item with the oldest expected triangle.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (surviving_triangles.size() == 0) begin
               error_count++;
               if (error_count + mismatch_count <= 10)
                  $display("unexpected triangle: %p", rsp_data);
            end else begin
               want = surviving_triangles.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count + error_count <= 10)
                     $display("mismatch on triangle %0d: expected %p, got %p",
                              want.out_index, want, rsp_data);
               end
            end
         end
         rsp_pop <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_VIEW_FORWARD:  cf_forward = val;
         CSR_VIEW_RIGHT:    cf_right = val;
         CSR_VIEW_UP:       cf_up = val;
         CSR_SCREEN_SCALE:  cf_scale = val[31:0];
         CSR_SCREEN_WIDTH:  cf_width = val[13:0];
         CSR_SCREEN_HEIGHT: cf_height = val[13:0];
         CSR_CLIP_X_LIMIT:  cf_clip_x = val[31:0];
         default:           cf_clip_y = val[31:0];
      endcase
   endtask

   task automatic set_config(logic [47:0] fwd, logic [47:0] rgt, logic [47:0] up,
                             logic [31:0] scale, logic [13:0] w, logic [13:0] h,
                             logic [31:0] cx, logic [31:0] cy);
      csr_write(CSR_VIEW_FORWARD, fwd);
      csr_write(CSR_VIEW_RIGHT, rgt);
      csr_write(CSR_VIEW_UP, up);
      csr_write(CSR_SCREEN_SCALE, {16'd0, scale});
      csr_write(CSR_SCREEN_WIDTH, {34'd0, w});
      csr_write(CSR_SCREEN_HEIGHT, {34'd0, h});
      csr_write(CSR_CLIP_X_LIMIT, {16'd0, cx});
      csr_write(CSR_CLIP_Y_LIMIT, {16'd0, cy});
      csr_valid <= 1'b0;
   endtask

   // Basis vector close to one axis, with small random leakage into the others.
   function automatic logic [47:0] near_axis(int axis, logic [15:0] main_comp);
      logic [15:0] c[3];
      for (int k = 0; k < 3; k++)
         c[k] = (k == axis) ? main_comp : 16'($urandom_range(1023)) - 16'd512;
      return {c[2], c[1], c[0]};
   endfunction

   function automatic logic [23:0] step_index(int max_step);
      next_index = next_index + 24'($urandom_range(max_step));
      return next_index;
   endfunction

   // Vertex whose x/z and y/z ratios land near a chosen screen direction.
   function automatic void near_vertex(int kx, int ky, int zsign,
                                       output logic [31:0] x, y, z);
      longint zz;
      zz = longint'($urandom_range(32'h0100_0000, 32'h0001_0000));
      x = 32'((zz * (kx + int'($urandom_range(40)) - 20)) / 1024);
      y = 32'((zz * (ky + int'($urandom_range(40)) - 20)) / 1024);
      z = 32'(zsign * zz);
   endfunction

   // Well-formed triangle inside the clip window; kinds 1 and 2 break one vertex.
   function automatic req_type well_formed(int span, int kind);
      req_type t;
      int kx, ky, zsign;
      zsign = $signed(cf_forward[47:32]) < 0 ? -1 : 1;
      kx = int'($urandom_range(2 * span)) - span;
      ky = int'($urandom_range(2 * span)) - span;
      t.tri_index = next_index;
      near_vertex(kx, ky, zsign, t.a_x, t.a_y, t.a_z);
      near_vertex(kx, ky, zsign, t.b_x, t.b_y, t.b_z);
      near_vertex(kx, ky, zsign, t.c_x, t.c_y, t.c_z);
      if (kind == 1) t.b_z = -t.b_z;
      if (kind == 2) t.c_x = t.c_z <<< 1;
      return t;
   endfunction

   function automatic req_type noise_triangle();
      req_type t;
      t = 312'({$urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom});
      t.tri_index = next_index;
      return t;
   endfunction

   // Wait until every item is taken and every surviving triangle has come out,
   // then let culled items still in the front queue and engine drain.
   task automatic wait_idle();
      while (triangles_pending.size() > 0 || req_push || surviving_triangles.size() > 0)
         @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic random_phase(int count, int span, int max_step);
      int roll;
      req_type t;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         // rare large jumps walk the index through its upper bits
         if ($urandom_range(49) == 0) void'(step_index(1 << 20));
         else void'(step_index(max_step));
         if (roll < 80) t = well_formed(span, 0);
         else if (roll < 90) t = well_formed(span, 1 + $urandom_range(1));
         else t = noise_triangle();
         triangles_pending.push_back(t);
      end
      wait_idle();
   endtask

   initial begin
      req_type t;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_VIEW_FORWARD;
      csr_wdata = '0;
      mismatch_count = 0;
      error_count = 0;
      next_index = '0;
      send_idle_pct = 14;
      recv_idle_pct = 87;
      cf_forward = 48'h4000_0000_0000;
      cf_right = 48'h0000_0000_4000;
      cf_up = 48'h0000_4000_0000;
      cf_scale = 32'h0001_0000;
      cf_width = 14'd640;
      cf_height = 14'd480;
      cf_clip_x = 32'h0001_0000;
      cf_clip_y = 32'h0001_0000;
      cur_group = '0;
      slot_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, screen offsets below one unit
      t = '0;
      triangles_pending.push_back(t);                 // zero forward dot
      t = '{24'd1, 32'sh1000, 32'sh800, 32'sha_0000, -32'sh1000, 32'sh1000,
            32'sha_0000, 32'sh0, -32'sh800, 32'sh9_0000};
      triangles_pending.push_back(t);                 // plain survivor
      t.tri_index = 24'd2; t.a_z = -32'sha_0000;
      triangles_pending.push_back(t);                 // first vertex behind
      t.tri_index = 24'd3; t.a_z = 32'sha_0000; t.b_z = 32'sh0;
      triangles_pending.push_back(t);                 // second vertex on the plane
      t.tri_index = 24'd4; t.b_z = 32'sha_0000; t.c_z = -32'sd1;
      triangles_pending.push_back(t);                 // third vertex just behind
      t.tri_index = 24'd5; t.c_z = 32'sh9_0000; t.a_x = 32'sha_0000;
      triangles_pending.push_back(t);                 // x offset exactly at limit
      t.tri_index = 24'd6; t.a_x = 32'sh9_ffff;
      triangles_pending.push_back(t);                 // x offset just inside
      t.tri_index = 24'd7; t.a_x = 32'sh0; t.b_y = -32'sha_0000;
      triangles_pending.push_back(t);                 // y offset at negative limit
      t.tri_index = 24'd8; t.b_y = 32'sh0; t.a_z = 32'sd1; t.b_z = 32'sd1;
      t.c_z = 32'sd1; t.a_x = '0; t.a_y = '0; t.b_x = '0; t.c_y = '0;
      triangles_pending.push_back(t);                 // depth saturates
      t = '{24'd9, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
            32'sh0, 32'sh0, 32'sh7fff_ffff};
      triangles_pending.push_back(t);                 // field extremes
      t = '{24'd9, 32'sh0, 32'sh0, 32'sh7fff_ffff, 32'sh0, 32'sh0, 32'sh7fff_ffff,
            32'sh0, 32'sh0, 32'sh7fff_ffff};
      triangles_pending.push_back(t);                 // repeated index, far depth
      t.tri_index = 24'd300;
      triangles_pending.push_back(t);                 // group change clears slots
      t.tri_index = 24'hff_ffff;
      triangles_pending.push_back(t);                 // last group
      next_index = 24'd0;
      for (int i = 0; i < 8; i++) begin
         void'(step_index(3));
         triangles_pending.push_back(well_formed(600, 0));
      end
      wait_idle();

      // every register written; wide screen, far clip
      set_config(near_axis(2, 16'h4000), near_axis(0, 16'h4000), near_axis(1, 16'hc000),
                 32'd300 << 16, 14'd8192, 14'd8192, 32'hffff_ffff, 32'hffff_ffff);
      random_phase(210, 900, 3);
      // tiny screen, zero scale and zero clip: nothing survives
      set_config(48'h4000_0000_0000, 48'h0000_0000_4000, 48'h0000_4000_0000,
                 32'd0, 14'd1, 14'd1, 32'd0, 32'd0);
      random_phase(210, 900, 3);

      send_idle_pct = 87;
      recv_idle_pct = 14;
      // full scale pushes most triangles off screen
      set_config(near_axis(2, 16'h7fff), near_axis(0, 16'h8000), near_axis(1, 16'h7fff),
                 32'hffff_ffff, 14'd640, 14'd480, 32'h0000_8000, 32'h0004_0000);
      random_phase(210, 700, 3);
      // forward vector pointing the other way
      set_config(near_axis(2, 16'hc000), near_axis(0, 16'h2000), near_axis(1, 16'h2000),
                 32'd200 << 16, 14'd1024, 14'd768, 32'h0002_0000, 32'h0002_0000);
      random_phase(210, 1500, 3);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(near_axis(2, 16'h4000), near_axis(0, 16'h4000), near_axis(1, 16'h4000),
                 32'd40 << 16, 14'd2048, 14'd2048, 32'h0001_8000, 32'h0001_8000);
      random_phase(210, 1200, 3);
      // one index repeated, bar rare large jumps, so survivors past 256 wrap the slot number
      set_config(48'h4000_0000_0000, 48'h0000_0000_4000, 48'h0000_4000_0000,
                 32'd100 << 16, 14'd640, 14'd480, 32'h0001_0000, 32'h0001_0000);
      random_phase(280, 500, 0);
      random_phase(20, 500, 3);

      if (mismatch_count == 0 && error_count == 0 && surviving_triangles.size() == 0) begin
         $display("triangle_project_and_cull regression: pass");
      end else begin
         $display("triangle_project_and_cull regression: fail");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("triangle_project_and_cull regression: fail");
      $finish;
   end

endmodule

@@ triangle_project_and_cull.f @@
design/tpc_pkg.sv
design/tpc_front.sv
design/tpc_div.sv
design/tpc_back.sv
design/tpc_rspq.sv
design/triangle_project_and_cull.sv
design/tpc_checker.sv
tb/testbench.sv
